// ===== design/upk_pkg.sv =====
`default_nettype none
package upk_pkg;

  localparam int S_DATA_W   = 40;
  localparam int M_DATA_W   = 56;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  // rows per frame never exceed this
  localparam int ROW_LIMIT = 4096;
  localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

  // request kinds on the input stream
  localparam logic [1:0] ACT_PIXEL   = 2'd0;
  localparam logic [1:0] ACT_PALETTE = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DEPTH_MODE      = 3'd0;
  localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_FRAME_HEIGHT    = 3'd2;
  localparam logic [2:0] CFG_ROW_BYTES       = 3'd3;
  localparam logic [2:0] CFG_PALETTE_ENTRIES = 3'd4;

  // pixel depth modes
  localparam logic [2:0] MODE_1BPP   = 3'd0;
  localparam logic [2:0] MODE_2BPP   = 3'd1;
  localparam logic [2:0] MODE_4BPP   = 3'd2;
  localparam logic [2:0] MODE_8BPP   = 3'd3;
  localparam logic [2:0] MODE_RGB555 = 3'd4;
  localparam logic [2:0] MODE_XRGB   = 3'd5;

  typedef enum logic [1:0] {
    KIND_PALETTE,
    KIND_INDEXED,
    KIND_DIRECT
  } kind_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [2:0]  depth_mode;
    logic [12:0] width;
    logic [11:0] row_last;
    logic [14:0] row_bytes;
    logic [7:0]  pal_last;
  } cfg_t;

  // work handed from the front end to the back end
  typedef struct packed {
    kind_t       kind;
    logic [23:0] rgb;
    logic [7:0]  byte_val;
    logic [2:0]  mode;
    logic [11:0] col;
    logic [3:0]  cnt;
    logic [11:0] row;
    logic        frame_end;
  } work_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] argb;
    logic        run_last;
    logic        frame_last;
  } pixel_t;

endpackage
`default_nettype wire

// ===== design/upk_ram.sv =====
`default_nettype none
module upk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/upk_fifo.sv =====
`default_nettype none
module upk_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  upk_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output upk_pkg::work_t pop_data,
  output logic           empty
);
  import upk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/upk_front.sv =====
`default_nettype none
module upk_front #(
  parameter int PALETTE_SIZE  = 256,
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic           clk,
  input  logic           rst,
  input  upk_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     pal_index,
  input  logic [23:0]    pal_rgb,
  output logic           push_valid,
  input  logic           push_ready,
  output upk_pkg::work_t push_data
);
  import upk_pkg::*;

  localparam int BW = $clog2(MAX_ROW_BYTES);
  localparam int CW = BW + 3;
  localparam int EW = ((CW > 13) ? CW : 13) + 1;
  localparam logic [8:0] PalSize = 9'(PALETTE_SIZE);

  logic [BW-1:0] byte_pos;
  logic [11:0]   row_count;
  logic [15:0]   partial;

  logic [15:0]   partial_next;
  logic [BW:0]   pos_inc;
  logic          wrap_row;
  logic [CW-1:0] base;
  logic [3:0]    ppb;
  logic [EW-1:0] base_x;
  logic [EW-1:0] width_x;
  logic [EW-1:0] span;
  logic [3:0]    cnt;
  logic [23:0]   direct_rgb;
  logic          frame_end;
  logic          accept;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ppb          = '0;
    base         = '0;
    direct_rgb   = '0;
    partial_next = partial;
    if (cfg.depth_mode <= MODE_8BPP) begin
      // first column of the byte: byte position times pixels per byte
      ppb  = 4'd8 >> cfg.depth_mode[1:0];
      base = CW'(byte_pos) << (2'd3 - cfg.depth_mode[1:0]);
    end else if (cfg.depth_mode == MODE_RGB555) begin
      base = CW'(byte_pos >> 1);
      if (byte_pos[0]) begin
        ppb        = 4'd1;
        direct_rgb = {widen5(partial[6:2]),
                      widen5({partial[1:0], data_byte[7:5]}),
                      widen5(data_byte[4:0])};
      end else begin
        partial_next = {8'h00, data_byte};
      end
    end else if (cfg.depth_mode == MODE_XRGB) begin
      base = CW'(byte_pos >> 2);
      unique case (byte_pos[1:0])
        2'd0: partial_next = '0;
        2'd1: partial_next = {8'h00, data_byte};
        2'd2: partial_next = {partial[7:0], data_byte};
        2'd3: begin
          ppb        = 4'd1;
          direct_rgb = {partial, data_byte};
        end
      endcase
    end

    // pixels past the visible width are dropped
    base_x  = EW'(base);
    width_x = EW'(cfg.width);
    span    = width_x - base_x;
    if (ppb == '0 || base_x >= width_x) begin
      cnt = '0;
    end else if (span > EW'(ppb)) begin
      cnt = ppb;
    end else begin
      cnt = span[3:0];
    end
    frame_end = (row_count == cfg.row_last) && (base_x + EW'(cnt) == width_x);

    pos_inc  = {1'b0, byte_pos} + 1'b1;
    wrap_row = 16'(pos_inc) >= 16'(cfg.row_bytes);
  end

  always_comb begin
    push_valid          = 1'b0;
    push_data           = '0;
    push_data.row       = row_count;
    push_data.mode      = cfg.depth_mode;
    push_data.col       = base[11:0];
    push_data.cnt       = cnt;
    push_data.frame_end = frame_end;
    if (in_action == ACT_PALETTE) begin
      push_valid         = in_valid && (9'(pal_index) < PalSize);
      push_data.kind     = KIND_PALETTE;
      push_data.byte_val = pal_index;
      push_data.rgb      = pal_rgb;
    end else if (in_action == ACT_PIXEL) begin
      push_valid         = in_valid && (cnt != '0);
      push_data.kind     = (cfg.depth_mode <= MODE_8BPP) ? KIND_INDEXED : KIND_DIRECT;
      push_data.byte_val = data_byte;
      push_data.rgb      = direct_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= '0;
      row_count <= '0;
      partial   <= '0;
    end else if (accept) begin
      if (in_action == ACT_RESTART) begin
        byte_pos  <= '0;
        row_count <= '0;
        partial   <= '0;
      end else if (in_action == ACT_PIXEL) begin
        partial <= partial_next;
        if (wrap_row) begin
          byte_pos  <= '0;
          row_count <= (row_count >= cfg.row_last) ? '0 : row_count + 1'b1;
        end else begin
          byte_pos <= pos_inc[BW-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/upk_back.sv =====
`default_nettype none
module upk_back #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      pal_last,
  input  logic            q_empty,
  input  upk_pkg::work_t  q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output upk_pkg::pixel_t out_pixel
);
  import upk_pkg::*;

  localparam int AW = $clog2(PALETTE_SIZE);

  work_t       cur;
  logic        cur_valid;
  logic [2:0]  k;

  logic        s2_valid;
  logic        s2_direct;
  logic        s2_hit;
  logic [23:0] s2_rgb;
  logic [7:0]  s2_idx;
  logic [11:0] s2_col;
  logic [11:0] s2_row;
  logic        s2_run_last;
  logic        s2_frame_last;
  pixel_t      s2_pix;

  logic [1:0]  occ;
  logic        wr_sel;
  logic        rd_sel;
  pixel_t      obuf [2];

  logic [PALETTE_SIZE-1:0] pal_valid;

  logic        pop_out;
  logic        credit_ok;
  logic        is_pal;
  logic        issue;
  logic        last_k;
  logic        done;
  logic        load;
  logic [2:0]  shamt;
  logic [7:0]  shifted;
  logic [7:0]  raw_idx;
  logic [7:0]  idx;
  logic        ram_we;
  logic        ram_re;
  logic [23:0] ram_q;

  assign out_valid = (occ != '0);
  assign pop_out   = out_valid && out_ready;
  assign out_pixel = obuf[rd_sel];

  // room for one more pixel: two output slots shared with the RAM stage
  assign credit_ok = (2'(occ) + 2'(s2_valid) < 2'd2) || out_ready;

  assign is_pal = cur_valid && (cur.kind == KIND_PALETTE);
  assign issue  = cur_valid && (cur.kind != KIND_PALETTE) && credit_ok;
  assign last_k = (k == 3'(cur.cnt - 4'd1));
  assign done   = is_pal || (issue && last_k);
  assign load   = !cur_valid || done;
  assign q_pop  = load && !q_empty;

  // MSB-first index extraction
  always_comb begin
    shamt   = k << cur.mode[1:0];
    shifted = cur.byte_val << shamt;
    unique case (cur.mode)
      MODE_1BPP: raw_idx = {7'd0, shifted[7]};
      MODE_2BPP: raw_idx = {6'd0, shifted[7:6]};
      MODE_4BPP: raw_idx = {4'd0, shifted[7:4]};
      default:   raw_idx = shifted;
    endcase
    idx = (raw_idx > pal_last) ? pal_last : raw_idx;
  end

  assign ram_we = is_pal;
  assign ram_re = issue && (cur.kind == KIND_INDEXED);

  upk_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.byte_val[AW-1:0]),
    .wdata (cur.rgb),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      pal_valid <= '0;
      s2_valid  <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= !q_empty;
        k         <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
      if (ram_we) begin
        pal_valid[cur.byte_val[AW-1:0]] <= 1'b1;
      end
      s2_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
    if (issue) begin
      s2_direct     <= (cur.kind == KIND_DIRECT);
      s2_rgb        <= cur.rgb;
      s2_idx        <= idx;
      s2_hit        <= pal_valid[idx[AW-1:0]];
      s2_col        <= cur.col + 12'(k);
      s2_row        <= cur.row;
      s2_run_last   <= last_k;
      s2_frame_last <= last_k && cur.frame_end;
    end
  end

  // entries never written read back as the gray ramp
  always_comb begin
    s2_pix.row        = s2_row;
    s2_pix.col        = s2_col;
    s2_pix.run_last   = s2_run_last;
    s2_pix.frame_last = s2_frame_last;
    if (s2_direct) begin
      s2_pix.argb = {OPAQUE_ALPHA, s2_rgb};
    end else if (s2_hit) begin
      s2_pix.argb = {OPAQUE_ALPHA, ram_q};
    end else begin
      s2_pix.argb = {OPAQUE_ALPHA, s2_idx, s2_idx, s2_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
    end else begin
      occ <= occ + 2'(s2_valid) - 2'(pop_out);
      if (s2_valid) begin
        wr_sel <= !wr_sel;
      end
      if (pop_out) begin
        rd_sel <= !rd_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      obuf[wr_sel] <= s2_pix;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ != 2'd3)
    else $error("output buffer overflow");

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pixel.frame_last |-> out_pixel.run_last)
    else $error("frame_last on a pixel that does not end its run");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("palette write and lookup in the same cycle");
`endif

endmodule
`default_nettype wire

// ===== design/framebuffer_pixel_unpacker_clut.sv =====
`default_nettype none
// Turns a big-endian frame buffer byte stream into ARGB8888 pixels, one pixel per
// cycle while the output takes them. Input requests are taken one per cycle by the
// front end while its queue has room; it tracks the row and byte position and
// queues work for the back end. A frame buffer byte gives 8 pixels in 1-bit mode,
// 4, 2 and 1 in 2-, 4- and 8-bit modes, less those past the visible width; 16- and
// 32-bit modes give one pixel every 2 or 4 bytes. Padding bytes, restarts and bytes
// that show nothing stay in the front end. A palette write passes to the back end
// and gives no pixel. The back end's single palette read port, one lookup per
// cycle while the output takes pixels, sets the pixel rate. A request's first pixel
// passes the queue, the work register, the RAM stage and an output slot. The palette
// comes out of reset as a gray ramp (per-entry valid bits, no clearing pass).
module framebuffer_pixel_unpacker_clut #(
  parameter int PALETTE_SIZE  = 256,
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [upk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upk_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_byte, pal_index, pal_red, pal_green, pal_blue
  input  logic [upk_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_argb, pixel_col, pixel_row
  output logic [upk_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  // frame_last
  output logic [0:0]                      m_axis_tuser
);
  import upk_pkg::*;

  localparam logic [12:0] WidthMax    = 13'(MAX_WIDTH);
  localparam logic [14:0] RowBytesMax = 15'(MAX_ROW_BYTES);
  localparam logic [8:0]  PalSize     = 9'(PALETTE_SIZE);
  localparam logic [12:0] RowMax      = 13'(ROW_LIMIT);

  logic [2:0]  depth_mode;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [14:0] row_bytes;
  logic [8:0]  palette_entries;

  cfg_t   cfg;
  logic   push_valid;
  logic   push_ready;
  work_t  push_data;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  work_t  q_data;
  pixel_t pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode      <= MODE_8BPP;
      frame_width     <= 13'd640;
      frame_height    <= 13'd480;
      row_bytes       <= 15'd640;
      palette_entries <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_MODE:      depth_mode      <= cfg_data[2:0];
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[12:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[12:0];
        CFG_ROW_BYTES:       row_bytes       <= cfg_data[14:0];
        CFG_PALETTE_ENTRIES: palette_entries <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.depth_mode = depth_mode;
    cfg.width      = (frame_width > WidthMax) ? WidthMax : frame_width;

    if (frame_height == '0) begin
      cfg.row_last = '0;
    end else if (frame_height > RowMax) begin
      cfg.row_last = 12'(ROW_LIMIT - 1);
    end else begin
      cfg.row_last = 12'(frame_height - 13'd1);
    end

    if (row_bytes == '0) begin
      cfg.row_bytes = 15'd1;
    end else if (row_bytes > RowBytesMax) begin
      cfg.row_bytes = RowBytesMax;
    end else begin
      cfg.row_bytes = row_bytes;
    end

    if (palette_entries == '0) begin
      cfg.pal_last = '0;
    end else if (palette_entries > PalSize) begin
      cfg.pal_last = 8'(PALETTE_SIZE - 1);
    end else begin
      cfg.pal_last = 8'(palette_entries - 9'd1);
    end
  end

  assign push_ready = !q_full;

  upk_front #(
    .PALETTE_SIZE  (PALETTE_SIZE),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .data_byte  (s_axis_tdata[7:0]),
    .pal_index  (s_axis_tdata[15:8]),
    .pal_rgb    ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  upk_fifo #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  upk_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pal_last  (cfg.pal_last),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (pix)
  );

  assign m_axis_tdata = {pix.row, pix.col, pix.argb};
  assign m_axis_tlast = pix.run_last;
  assign m_axis_tuser = pix.frame_last;

endmodule
`default_nettype wire
